/* rtl/brle_pkg.sv */
// ----------------------------------------------------------------------------
// brle_pkg
// Shared constants and types for the bit run-length encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package brle_pkg;

   // Characters kept per message before the rest is dropped
   localparam int MAX_CHARS   = 256;
   // Width of the run counter, saturates at all ones
   localparam int RUN_BITS    = 16;
   // Width of one emitted code
   localparam int CODE_W      = 17;
   // Input byte width and number of encoded bits (bit 7 ignored)
   localparam int CHAR_W      = 8;
   localparam int CHAR_BITS   = 7;
   // Offset added to the code of a run of ones
   localparam int ONE_BASE    = 10;

   localparam int CNT_W       = $clog2(MAX_CHARS + 1);
   localparam int IDX_W       = $clog2(CHAR_BITS);
   localparam int SUM_W       = ((RUN_BITS > CODE_W) ? RUN_BITS : CODE_W) + 1;

   // Queue between front and back, depth is a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One kept character with its end-of-message mark
   typedef struct packed {
      logic [CHAR_BITS-1:0] bits;
      logic                 ending;
   } job_type;

   // A job offered across the queue boundary
   typedef struct packed {
      logic    valid;
      job_type job;
   } slot_type;

endpackage

`default_nettype wire

/* rtl/brle_front.sv */
// ----------------------------------------------------------------------------
// brle_front
// Accepts input words, tracks the per-message character count and drop
// state, and queues kept characters with their end-of-message flag.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [brle_pkg::CHAR_W-1:0]   req_character,
   input  wire logic                          req_final_char,
   input  wire logic                          q_full,
   output brle_pkg::slot_type                 push
);

   logic [brle_pkg::CNT_W-1:0] chars_ff, chars_in;
   logic                       dropping_ff, dropping_in;
   logic [brle_pkg::CNT_W-1:0] chars_next;
   logic                       accept;
   logic                       ending;

   assign req_stall  = q_full;
   assign accept     = req_valid && !q_full;
   assign chars_next = chars_ff + brle_pkg::CNT_W'(1);
   assign ending     = req_final_char ||
                       (chars_next >= brle_pkg::CNT_W'(brle_pkg::MAX_CHARS));

   // Classify: dropped words never reach the queue
   always_comb begin
      push.valid    = accept && !dropping_ff;
      push.job.bits = req_character[brle_pkg::CHAR_BITS-1:0];
      push.job.ending = ending;
   end

   // Message bookkeeping
   always_comb begin
      chars_in    = chars_ff;
      dropping_in = dropping_ff;
      if (accept) begin
         if (dropping_ff) begin
            if (req_final_char) begin
               dropping_in = 1'b0;
               chars_in    = '0;
            end
         end else if (ending) begin
            chars_in    = '0;
            dropping_in = !req_final_char;
         end else begin
            chars_in = chars_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_ff    <= '0;
         dropping_ff <= 1'b0;
      end else begin
         chars_ff    <= chars_in;
         dropping_ff <= dropping_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/brle_queue.sv */
// ----------------------------------------------------------------------------
// brle_queue
// Short FIFO of kept characters between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire brle_pkg::slot_type push,
   output logic                    full,
   output brle_pkg::slot_type      head,
   input  wire logic               pop
);

   brle_pkg::job_type                  store_ff [brle_pkg::QUEUE_DEPTH];
   logic [brle_pkg::QPTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [brle_pkg::QCNT_W-1:0]        count_ff;
   logic                               do_push, do_pop;

   assign full     = (count_ff == brle_pkg::QCNT_W'(brle_pkg::QUEUE_DEPTH));
   assign do_push  = push.valid && !full;
   assign do_pop   = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.job   = store_ff[rd_ptr_ff];

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push.job;
      end
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + brle_pkg::QPTR_W'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + brle_pkg::QPTR_W'(1);
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + brle_pkg::QCNT_W'(1);
            2'b01:   count_ff <= count_ff - brle_pkg::QCNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

/* rtl/brle_back.sv */
// ----------------------------------------------------------------------------
// brle_back
// Bit-serial run scanner: walks bits 6..0 of each queued character, one per
// cycle unless stalled, emits a code at each bit change, flushes at message end.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire brle_pkg::slot_type            head,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [brle_pkg::CODE_W-1:0]        rsp_run_code,
   output logic                               rsp_last_of_item,
   output logic                               rsp_message_end
);

   // Current character
   logic                            busy_ff;
   logic [brle_pkg::CHAR_BITS-1:0]  bits_ff;
   logic                            ending_ff;
   logic [brle_pkg::IDX_W-1:0]      idx_ff;
   logic                            flush_ff;
   // Run state
   logic                            have_ff, have_in;
   logic                            prev_ff, prev_in;
   logic [brle_pkg::RUN_BITS-1:0]   run_ff, run_in;
   // Output word register
   logic                            rsp_valid_ff;
   logic [brle_pkg::CODE_W-1:0]     code_ff;
   logic                            last_ff;
   logic                            end_ff;

   logic                            out_ready;
   logic                            cur_bit;
   logic                            emit;
   logic                            advance;
   logic                            finish;
   logic                            emit_last;
   logic [brle_pkg::CHAR_BITS-1:0]  low_mask;
   logic [brle_pkg::CHAR_BITS-1:0]  low_bits;
   logic                            rest_same;
   logic [brle_pkg::RUN_BITS-1:0]   run_inc;
   logic [brle_pkg::SUM_W-1:0]      code_sum;
   logic [brle_pkg::CODE_W-1:0]     code_val;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign cur_bit   = bits_ff[idx_ff];

   // Does this step emit a word
   assign emit = busy_ff && (flush_ff || (have_ff && (prev_ff != cur_bit)));
   assign advance = busy_ff && (!emit || out_ready);
   assign finish  = advance && (flush_ff || ((idx_ff == '0) && !ending_ff));
   assign pop     = head.valid && (!busy_ff || finish);

   // Remaining bits of the character equal the current one: no later change
   assign low_mask  = {brle_pkg::CHAR_BITS{1'b1}} >>
                      (brle_pkg::IDX_W'(brle_pkg::CHAR_BITS - 1) - idx_ff);
   assign low_bits  = bits_ff & low_mask;
   assign rest_same = cur_bit ? (low_bits == low_mask) : (low_bits == '0);
   assign emit_last = flush_ff || (!ending_ff && rest_same);

   // Code of the run that just closed
   always_comb begin
      code_sum = (run_ff == '0) ? '0
               : brle_pkg::SUM_W'(run_ff) - brle_pkg::SUM_W'(1);
      if (prev_ff) begin
         code_sum = code_sum + brle_pkg::SUM_W'(brle_pkg::ONE_BASE);
      end
      code_val = code_sum[brle_pkg::CODE_W-1:0];
   end

   assign run_inc = (run_ff == '1) ? run_ff : run_ff + brle_pkg::RUN_BITS'(1);

   // Run state update for one step
   always_comb begin
      have_in = have_ff;
      prev_in = prev_ff;
      run_in  = run_ff;
      if (advance) begin
         if (flush_ff) begin
            have_in = 1'b0;
            prev_in = 1'b0;
            run_in  = '0;
         end else begin
            have_in = 1'b1;
            prev_in = cur_bit;
            run_in  = emit ? brle_pkg::RUN_BITS'(1) : run_inc;
         end
      end
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         flush_ff  <= 1'b0;
         idx_ff    <= '0;
         have_ff   <= 1'b0;
         prev_ff   <= 1'b0;
         run_ff    <= '0;
      end else begin
         have_ff <= have_in;
         prev_ff <= prev_in;
         run_ff  <= run_in;
         if (pop) begin
            busy_ff   <= 1'b1;
            bits_ff   <= head.job.bits;
            ending_ff <= head.job.ending;
            idx_ff    <= brle_pkg::IDX_W'(brle_pkg::CHAR_BITS - 1);
            flush_ff  <= 1'b0;
         end else if (finish) begin
            busy_ff  <= 1'b0;
            flush_ff <= 1'b0;
         end else if (advance) begin
            if (idx_ff == '0) begin
               flush_ff <= 1'b1;
            end else begin
               idx_ff <= idx_ff - brle_pkg::IDX_W'(1);
            end
         end
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit && out_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit && out_ready) begin
         code_ff <= code_val;
         last_ff <= emit_last;
         end_ff  <= flush_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_run_code     = code_ff;
   assign rsp_last_of_item = last_ff;
   assign rsp_message_end  = end_ff;

endmodule

`default_nettype wire

/* rtl/bit_run_length_encoder.sv */
// ----------------------------------------------------------------------------
// bit_run_length_encoder
// Encodes bits 6..0 of each character as run-length codes.
//
// Input channel (req_): one character per word plus a final_char flag.
// Result channel (rsp_): one run code per word; last_of_item marks the last
// code a character causes, message_end marks the flush code closing a message.
// A zero run of length L gives L-1, a one run gives 10+L-1.
// The front counts characters per message and drops those past the limit;
// the back scans one bit per cycle unless stalled, and adds a flush code
// when a character ends a message. Dropped characters are consumed in the
// front. Throughput is bound by the bit-serial back scanner.
// Path to rsp_: queue entry, back character register, output word register.
// A two-entry queue lets the front keep taking words while the back works.
// When rsp_stall is high, the held word stays unchanged and the back pauses
// on its next emitting step; req_stall rises once the queue is full.
// Synchronous reset empties the queue, drops any word in flight and returns
// all run and message state to "no bit seen".
// ----------------------------------------------------------------------------
`default_nettype none

module bit_run_length_encoder (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [brle_pkg::CHAR_W-1:0]   req_character,
   input  wire logic                          req_final_char,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [brle_pkg::CODE_W-1:0]        rsp_run_code,
   output logic                               rsp_last_of_item,
   output logic                               rsp_message_end
);

   brle_pkg::slot_type push;
   brle_pkg::slot_type head;
   logic               q_full;
   logic               pop;

   brle_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_character  (req_character),
      .req_final_char (req_final_char),
      .q_full         (q_full),
      .push           (push)
   );

   brle_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .head  (head),
      .pop   (pop)
   );

   brle_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_run_code     (rsp_run_code),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_message_end  (rsp_message_end)
   );

endmodule

`default_nettype wire

/* rtl/brle_checker.sv */
// ----------------------------------------------------------------------------
// brle_checker
// Port-level checks on the result channel of the encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [brle_pkg::CODE_W-1:0]   rsp_run_code,
   input  wire logic                          rsp_last_of_item,
   input  wire logic                          rsp_message_end
);

   // A stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_run_code) &&
         $stable(rsp_last_of_item) && $stable(rsp_message_end))
      else $error("stalled result word changed");

   // The closing flush code is always the last code of its character
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_end |-> rsp_last_of_item)
      else $error("message end without last_of_item");

   // Nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A code mid-character is a run change, which lies within the run range
   a_mid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_message_end |->
         rsp_run_code <= brle_pkg::CODE_W'(((1 << brle_pkg::RUN_BITS) - 2)
                                          + brle_pkg::ONE_BASE)
         || brle_pkg::RUN_BITS + 1 > brle_pkg::CODE_W)
      else $error("run code out of range");

endmodule

bind bit_run_length_encoder brle_checker u_brle_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_run_code     (rsp_run_code),
   .rsp_last_of_item (rsp_last_of_item),
   .rsp_message_end  (rsp_message_end)
);

`default_nettype wire

/* bench/tb_bit_run_length_encoder.sv */
// ----------------------------------------------------------------------------
// tb_bit_run_length_encoder
// Self-checking bench for the bit run-length encoder. Characters are sent as
// whole messages and a local run-length model predicts every code word they
// cause. A checker compares each accepted code word, field by field, with the
// oldest prediction. Runs go through directed single-character and
// multi-character messages, the per-message character limit with dropping,
// and random messages under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_bit_run_length_encoder;

   localparam logic [1:0] NO_BIT       = 2'd2;
   localparam int         DRAIN_CYCLES = 40;
   localparam int         REPORT_MAX   = 10;

   // One predicted code word
   typedef struct packed {
      logic [brle_pkg::CODE_W-1:0] code;
      logic                        last_of_item;
      logic                        message_end;
   } run_word_type;

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic                          req_stall;
   logic [brle_pkg::CHAR_W-1:0]   req_character  = '0;
   logic                          req_final_char = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall      = 1'b0;
   logic [brle_pkg::CODE_W-1:0]   rsp_run_code;
   logic                          rsp_last_of_item;
   logic                          rsp_message_end;

   // Encoder model state
   logic [1:0]                    prev_bit   = NO_BIT;
   logic [brle_pkg::RUN_BITS-1:0] zero_len   = '0;
   logic [brle_pkg::RUN_BITS-1:0] one_len    = '0;
   int unsigned                   kept_chars = 0;
   logic                          dropping   = 1'b0;

   run_word_type        expected_codes[$];

   int                  send_idle_pct = 0;
   int                  stall_pct     = 0;
   int                  mismatches    = 0;
   int                  chars_sent    = 0;
   int                  messages_sent = 0;
   int                  chars_dropped = 0;
   int                  words_checked = 0;

   bit_run_length_encoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_character    (req_character),
      .req_final_char   (req_final_char),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_run_code     (rsp_run_code),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_message_end  (rsp_message_end)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

   // Receiver back-pressure, re-rolled every cycle
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // ------------------------------------------------------------------------
   // Encoder model
   // ------------------------------------------------------------------------
   function automatic logic [brle_pkg::CODE_W-1:0] run_code(
      logic bit_val, logic [brle_pkg::RUN_BITS-1:0] len);
      logic [63:0] sum;
      sum = (len == '0) ? 64'd0 : 64'(len) - 64'd1;
      if (bit_val) begin
         sum = sum + 64'(brle_pkg::ONE_BASE);
      end
      return sum[brle_pkg::CODE_W-1:0];
   endfunction

   function automatic logic [brle_pkg::RUN_BITS-1:0] run_inc(
      logic [brle_pkg::RUN_BITS-1:0] len);
      // counters hold at all ones
      return (len == '1) ? len : len + brle_pkg::RUN_BITS'(1);
   endfunction

   function automatic run_word_type make_word(logic [brle_pkg::CODE_W-1:0] code,
                                              logic msg_end);
      run_word_type w;
      w.code         = code;
      w.last_of_item = 1'b0;
      w.message_end  = msg_end;
      return w;
   endfunction

   // Queue the code words one accepted character causes
   function automatic void predict_run_codes(logic [brle_pkg::CHAR_W-1:0] ch, logic fin);
      run_word_type words[$];
      logic         bit_val;
      logic         ending;
      if (dropping) begin
         chars_dropped++;
         if (fin) begin
            dropping   = 1'b0;
            kept_chars = 0;
         end
         return;
      end
      kept_chars++;
      ending = fin || (kept_chars >= brle_pkg::MAX_CHARS);
      // scan bits 6..0, MSB first
      for (int b = brle_pkg::CHAR_BITS - 1; b >= 0; b--) begin
         bit_val = ch[b];
         if (prev_bit != NO_BIT && prev_bit[0] != bit_val) begin
            if (prev_bit[0] == 1'b0) begin
               words.push_back(make_word(run_code(1'b0, zero_len), 1'b0));
               zero_len = '0;
            end else begin
               words.push_back(make_word(run_code(1'b1, one_len), 1'b0));
               one_len = '0;
            end
         end
         if (bit_val) begin
            one_len = run_inc(one_len);
         end else begin
            zero_len = run_inc(zero_len);
         end
         prev_bit = {1'b0, bit_val};
      end
      // flush the open run at the end of the message
      if (ending) begin
         if (prev_bit[0] == 1'b0) begin
            words.push_back(make_word(run_code(1'b0, zero_len), 1'b1));
         end else begin
            words.push_back(make_word(run_code(1'b1, one_len), 1'b1));
         end
         prev_bit   = NO_BIT;
         zero_len   = '0;
         one_len    = '0;
         kept_chars = 0;
         if (!fin) begin
            dropping = 1'b1;
         end
      end
      if (words.size() > 0) begin
         words[words.size() - 1].last_of_item = 1'b1;
      end
      foreach (words[i]) begin
         expected_codes.push_back(words[i]);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      run_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_codes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("%0t: unexpected word code=%0d last=%b end=%b", $time,
                        rsp_run_code, rsp_last_of_item, rsp_message_end);
            end
         end else begin
            want = expected_codes.pop_front();
            words_checked++;
            if (rsp_run_code !== want.code || rsp_last_of_item !== want.last_of_item ||
                rsp_message_end !== want.message_end) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("%0t: expected code=%0d last=%b end=%b, %s",
                           $time, want.code, want.last_of_item, want.message_end,
                           $sformatf("got code=%0d last=%b end=%b",
                                     rsp_run_code, rsp_last_of_item, rsp_message_end));
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   // Send one character word; valid stays high after acceptance
   task automatic send_char(input logic [brle_pkg::CHAR_W-1:0] ch, input logic fin);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_character  <= ch;
      req_final_char <= fin;
      do @(posedge clock); while (req_stall);
      predict_run_codes(ch, fin);
      chars_sent++;
      if (fin) begin
         messages_sent++;
      end
   endtask

   // Lower valid and wait until every predicted word has come out
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Short messages: all-zero, all-one, alternating, lone final zero,
   // runs spanning characters and the eight-word worst case
   task automatic test_directed_runs();
      send_char(8'h00, 1'b1);
      send_char(8'h7F, 1'b1);
      send_char(8'hFF, 1'b1);
      send_char(8'h80, 1'b1);
      send_char(8'h7E, 1'b1);   // lone zero after ones
      send_char(8'h01, 1'b1);
      send_char(8'h55, 1'b1);
      send_char(8'h2A, 1'b0);   // then 0x55: eight words on one character
      send_char(8'h55, 1'b1);
      send_char(8'h00, 1'b0);   // zero run across three characters
      send_char(8'h80, 1'b0);
      send_char(8'h00, 1'b1);
      send_char(8'h7F, 1'b0);   // one run across four characters
      send_char(8'hFF, 1'b0);
      send_char(8'h7F, 1'b0);
      send_char(8'h7F, 1'b1);
      send_char(8'h0F, 1'b0);
      send_char(8'hF0, 1'b1);
   endtask

   // Message reaching the character limit, its dropped tail closed by a
   // final flag, then a short message that must start from a clean state
   task automatic test_char_limit();
      for (int i = 0; i < brle_pkg::MAX_CHARS; i++) begin
         send_char({i[0], 7'h00}, 1'b0);
      end
      for (int i = 0; i < 3; i++) begin
         send_char(brle_pkg::CHAR_W'($urandom_range(0, 255)), 1'b0);
      end
      send_char(brle_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1);
      send_char(8'h3C, 1'b1);
   endtask

   // Random messages; content mixes uniform bytes with run-friendly patterns
   task automatic test_random_messages(input int num_chars);
      int                          sent;
      int                          msg_len;
      logic [brle_pkg::CHAR_W-1:0] ch;
      sent = 0;
      while (sent < num_chars) begin
         msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40)
                                                 : $urandom_range(1, 8);
         for (int i = 0; i < msg_len; i++) begin
            case ($urandom_range(0, 7))
               0:       ch = 8'h00;
               1:       ch = 8'h7F;
               2:       ch = 8'h40;
               3:       ch = 8'h01;
               default: ch = brle_pkg::CHAR_W'($urandom_range(0, 255));
            endcase
            ch[7] = 1'($urandom_range(0, 1));
            send_char(ch, (i == msg_len - 1));
         end
         sent += msg_len;
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // slow receiver
      send_idle_pct = 16;
      stall_pct     = 83;
      test_directed_runs();
      test_random_messages(60);
      drain_results();

      // slow sender
      send_idle_pct = 83;
      stall_pct     = 16;
      test_char_limit();
      test_random_messages(60);
      drain_results();

      // full rate on both sides
      send_idle_pct = 0;
      stall_pct     = 0;
      test_random_messages(60);
      drain_results();

      $display("Sent %0d characters in %0d messages (%0d dropped past the limit).",
               chars_sent, messages_sent, chars_dropped);
      $display("Checked %0d run codes, %0d mismatches.", words_checked, mismatches);
      if (mismatches == 0 && expected_codes.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
